[rtl/core/flvtsl_pkg.sv]
// Package with the types, widths and constants of the tag stream length checker.
package flvtsl_pkg;

   localparam int POSITION_BITS_DEF = 34;
   localparam int LEN_W             = 34;
   localparam int COUNT_W           = 22;
   localparam int OFFSET_W          = 16;
   localparam int MIN_TAGS_W        = 8;
   localparam int HDR_W             = 32;
   localparam int PAYLOAD_W         = 24;
   localparam int TAG_IDX_W         = 4;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 22;

   localparam logic [OFFSET_W-1:0]   MAX_HDR_OFF_RST = 16'd1024;
   localparam logic [COUNT_W-1:0]    TAG_LIMIT_RST   = 22'd4000000;
   localparam logic [MIN_TAGS_W-1:0] MIN_TAGS_RST    = 8'd2;

   localparam logic [7:0] SIG_F = 8'h46;
   localparam logic [7:0] SIG_L = 8'h4C;
   localparam logic [7:0] SIG_V = 8'h56;

   localparam int SIG_F_POS     = 0;
   localparam int SIG_L_POS     = 1;
   localparam int SIG_V_POS     = 2;
   localparam int HDR_OFF_FIRST = 5;
   localparam int HDR_OFF_LAST  = 8;
   localparam int HDR_OFF_MIN   = 9;
   localparam int TAIL_BYTES    = 4;

   localparam logic [TAG_IDX_W-1:0] TAG_TYPE_IDX   = 4'd4;
   localparam logic [TAG_IDX_W-1:0] TAG_SIZE_FIRST = 4'd5;
   localparam logic [TAG_IDX_W-1:0] TAG_SIZE_LAST  = 4'd7;
   localparam logic [TAG_IDX_W-1:0] TAG_HDR_LAST   = 4'd14;

   localparam logic [4:0] TAG_TYPE_MASK = 5'h1F;
   localparam logic [4:0] TAG_AUDIO     = 5'd8;
   localparam logic [4:0] TAG_VIDEO     = 5'd9;
   localparam logic [4:0] TAG_SCRIPT    = 5'd18;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIP,
      PH_TAGHDR,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_HDR_OFF,
      CSR_TAG_LIMIT,
      CSR_MIN_TAGS
   } csr_index_type;

endpackage

[rtl/core/flv_tag_stream_length.sv]
// Top level of the tag stream length checker: header check, tag walk and result word.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_ready   | data_byte, first_byte, last_byte
//   rsp     | out       | rsp_valid / rsp_ready   | found, stream_length, tag_count
//   csr     | in        | csr_write_en            | csr_index, csr_wdata
//
// One byte word is taken per cycle while rsp is not stalled; each word is held in the input register and
// its result word, if any, is then registered in the output register.
// The per-byte walk state is updated as each word leaves the input register, which sets the rate of one word per cycle.
// Reset is synchronous; there is no clearing pass.
// A stall on rsp holds the output register and the input register, then blocks req.
module flv_tag_stream_length
   import flvtsl_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [LEN_W-1:0]      rsp_stream_length,
   output logic [COUNT_W-1:0]    rsp_tag_count,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EXT_W = ((POSITION_BITS > LEN_W) ? POSITION_BITS : LEN_W) + 1;
   localparam int CMP_W = (POSITION_BITS > HDR_W) ? POSITION_BITS : HDR_W;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [LEN_W-1:0]         LEN_MAX = {LEN_W{1'b1}};

   logic [OFFSET_W-1:0]      max_hdr_off_ff;
   logic [COUNT_W-1:0]       tag_limit_ff;
   logic [MIN_TAGS_W-1:0]    min_tags_ff;

   logic                     stage_valid_ff, stage_valid_in;
   logic [7:0]               stage_byte_ff;
   logic                     stage_first_ff;
   logic                     stage_last_ff;
   logic                     req_accept;
   logic                     stage_advance;

   phase_type                phase_ff, phase_in, cur_phase;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, cur_pos, pos_inc;
   logic [HDR_W-1:0]         hdr_off_ff, hdr_off_in, cur_hdr, hdr_shift;
   logic [TAG_IDX_W-1:0]     tag_idx_ff, tag_idx_in, cur_idx;
   logic [PAYLOAD_W-1:0]     pay_rem_ff, pay_rem_in, cur_pay;
   logic [COUNT_W-1:0]       tags_done_ff, tags_done_in, cur_tags, tags_inc;
   logic [LEN_W-1:0]         end_len_ff, end_len_in, cur_end_len, tag_end_len;
   logic                     sig_ok_ff, sig_ok_in, cur_sig_ok;
   logic [EXT_W-1:0]         tag_end_ext;
   logic                     active;
   logic                     type_ok;
   logic                     finish;
   logic                     complete;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]         rsp_len_ff, rsp_len_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_off_ff <= MAX_HDR_OFF_RST;
         tag_limit_ff   <= TAG_LIMIT_RST;
         min_tags_ff    <= MIN_TAGS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_HDR_OFF: max_hdr_off_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_TAG_LIMIT:   tag_limit_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_MIN_TAGS:    min_tags_ff    <= csr_wdata[MIN_TAGS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register and flow control.
   assign stage_advance  = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || stage_advance;
   assign req_accept     = req_valid && req_ready;
   assign stage_valid_in = req_accept || (stage_valid_ff && !stage_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_byte_ff  <= req_data_byte;
         stage_first_ff <= req_first_byte;
         stage_last_ff  <= req_last_byte;
      end
   end

   // A first byte restarts the walk from a clean state.
   assign cur_phase   = stage_first_ff ? PH_HEADER : phase_ff;
   assign cur_pos     = stage_first_ff ? '0 : pos_ff;
   assign cur_hdr     = stage_first_ff ? '0 : hdr_off_ff;
   assign cur_idx     = stage_first_ff ? '0 : tag_idx_ff;
   assign cur_pay     = stage_first_ff ? '0 : pay_rem_ff;
   assign cur_tags    = stage_first_ff ? '0 : tags_done_ff;
   assign cur_end_len = stage_first_ff ? LEN_W'(TAIL_BYTES) : end_len_ff;
   assign cur_sig_ok  = stage_first_ff ? 1'b0 : sig_ok_ff;
   assign active      = stage_first_ff || (phase_ff != PH_IDLE);

   assign pos_inc   = (cur_pos == POS_MAX) ? cur_pos : cur_pos + POSITION_BITS'(1);
   assign hdr_shift = {cur_hdr[HDR_W-9:0], stage_byte_ff};
   assign tags_inc  = cur_tags + COUNT_W'(1);
   assign type_ok   = (stage_byte_ff[4:0] & TAG_TYPE_MASK) inside
                      {TAG_AUDIO, TAG_VIDEO, TAG_SCRIPT};

   assign tag_end_ext = (cur_pos == POS_MAX) ?
                        EXT_W'(cur_pos) + EXT_W'(TAIL_BYTES) :
                        EXT_W'(cur_pos) + EXT_W'(TAIL_BYTES + 1);
   assign tag_end_len = (tag_end_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : tag_end_ext[LEN_W-1:0];

   always_comb begin
      phase_in     = cur_phase;
      pos_in       = cur_pos;
      hdr_off_in   = cur_hdr;
      tag_idx_in   = cur_idx;
      pay_rem_in   = cur_pay;
      tags_done_in = cur_tags;
      end_len_in   = cur_end_len;
      sig_ok_in    = cur_sig_ok;
      finish       = 1'b0;
      complete     = 1'b0;
      if (active) begin
         pos_in = pos_inc;
         case (cur_phase)
            PH_HEADER: begin
               if ((cur_pos == POSITION_BITS'(SIG_F_POS) && stage_byte_ff != SIG_F) ||
                   (cur_pos == POSITION_BITS'(SIG_L_POS) && stage_byte_ff != SIG_L) ||
                   (cur_pos == POSITION_BITS'(SIG_V_POS) && stage_byte_ff != SIG_V)) begin
                  finish = 1'b1;
               end else begin
                  if (cur_pos >= POSITION_BITS'(HDR_OFF_FIRST) &&
                      cur_pos <= POSITION_BITS'(HDR_OFF_LAST)) begin
                     hdr_off_in = hdr_shift;
                  end
                  if (cur_pos == POSITION_BITS'(HDR_OFF_LAST)) begin
                     if (hdr_shift < HDR_W'(HDR_OFF_MIN) ||
                         hdr_shift > HDR_W'(max_hdr_off_ff)) begin
                        finish = 1'b1;
                     end else begin
                        sig_ok_in  = 1'b1;
                        end_len_in = LEN_W'(hdr_shift[OFFSET_W-1:0]) + LEN_W'(TAIL_BYTES);
                        tag_idx_in = '0;
                        if (tag_limit_ff == '0) begin
                           finish = 1'b1;
                        end else if (hdr_shift == HDR_W'(HDR_OFF_MIN)) begin
                           phase_in = PH_TAGHDR;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
               end
            end
            PH_SKIP: begin
               if (CMP_W'(pos_inc) >= CMP_W'(cur_hdr)) begin
                  tag_idx_in = '0;
                  phase_in   = PH_TAGHDR;
               end
            end
            PH_TAGHDR: begin
               if (cur_idx == TAG_TYPE_IDX && !type_ok) begin
                  finish = 1'b1;
               end else begin
                  if (cur_idx >= TAG_SIZE_FIRST && cur_idx <= TAG_SIZE_LAST) begin
                     pay_rem_in = {cur_pay[PAYLOAD_W-9:0], stage_byte_ff};
                  end
                  if (cur_idx >= TAG_HDR_LAST) begin
                     if (cur_pay == '0) begin
                        complete = 1'b1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else begin
                     tag_idx_in = cur_idx + TAG_IDX_W'(1);
                  end
               end
            end
            PH_PAYLOAD: begin
               pay_rem_in = cur_pay - PAYLOAD_W'(1);
               if (cur_pay == PAYLOAD_W'(1)) begin
                  complete = 1'b1;
               end
            end
            default: ;
         endcase
         if (complete) begin
            tags_done_in = tags_inc;
            end_len_in   = tag_end_len;
            tag_idx_in   = '0;
            phase_in     = PH_TAGHDR;
            if (tags_inc >= tag_limit_ff) begin
               finish = 1'b1;
            end
         end
         if (stage_last_ff) begin
            finish = 1'b1;
         end
         if (finish) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // Walk state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pos_ff       <= '0;
         hdr_off_ff   <= '0;
         tag_idx_ff   <= '0;
         pay_rem_ff   <= '0;
         tags_done_ff <= '0;
         end_len_ff   <= LEN_W'(TAIL_BYTES);
         sig_ok_ff    <= 1'b0;
      end else if (stage_advance) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         hdr_off_ff   <= hdr_off_in;
         tag_idx_ff   <= tag_idx_in;
         pay_rem_ff   <= pay_rem_in;
         tags_done_ff <= tags_done_in;
         end_len_ff   <= end_len_in;
         sig_ok_ff    <= sig_ok_in;
      end
   end

   // Output register.
   assign rsp_found_in = sig_ok_in && (tags_done_in >= COUNT_W'(min_tags_ff));
   assign rsp_len_in   = rsp_found_in ? end_len_in : '0;
   assign rsp_count_in = sig_ok_in ? tags_done_in : '0;
   assign rsp_valid_in = stage_advance ? finish : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_advance && finish) begin
         rsp_found_ff <= rsp_found_in;
         rsp_len_ff   <= rsp_len_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_stream_length = rsp_len_ff;
   assign rsp_tag_count     = rsp_count_ff;

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> pay_rem_ff != '0)
      else $error("payload phase entered with no payload bytes left");

   a_walk_needs_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP || phase_ff == PH_TAGHDR || phase_ff == PH_PAYLOAD) |-> sig_ok_ff)
      else $error("tag walk running without a valid header");

   a_found_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |->
         rsp_count_ff >= COUNT_W'(min_tags_ff) && rsp_len_ff != '0)
      else $error("found word with too few tags or zero length");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while both registers are full and stalled");

endmodule
